>>> rtl/core/ccfu_pkg.sv
// ----------------------------------------------------------------------------
// ccfu_pkg: condition code flag unit shared definitions
// Field widths, rule codes and the item/flag structs used by the flag unit.
// ----------------------------------------------------------------------------
package ccfu_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned SizeW  = 2;
  localparam int unsigned CRuleW = 4;
  localparam int unsigned VRuleW = 3;

  typedef enum logic [SizeW-1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_WORD = 2'd1,
    SIZE_LONG = 2'd2,
    SIZE_ALT  = 2'd3
  } size_code_t;

  typedef enum logic [CRuleW-1:0] {
    C_KEEP  = 4'd0,
    C_CLEAR = 4'd1,
    C_SET   = 4'd2,
    C_ADD   = 4'd3,
    C_SUB   = 4'd4,
    C_LEFT  = 4'd5,
    C_RIGHT = 4'd6,
    C_ASH   = 4'd7,
    C_MUL   = 4'd8,
    C_DIV   = 4'd9
  } carry_rule_t;

  typedef enum logic [VRuleW-1:0] {
    V_KEEP  = 3'd0,
    V_CLEAR = 3'd1,
    V_ADD   = 3'd2,
    V_SUB   = 3'd3,
    V_SHIFT = 3'd4,
    V_ASH   = 3'd5,
    V_DIV   = 3'd6
  } overflow_rule_t;

  typedef struct packed {
    logic [DataW-1:0]  result_value;
    logic [DataW-1:0]  source_value;
    logic [DataW-1:0]  dest_value;
    logic [SizeW-1:0]  size_code;
    logic [CRuleW-1:0] carry_rule;
    logic [VRuleW-1:0] overflow_rule;
    logic              update_negative;
    logic              update_zero;
  } ccfu_item_t;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } ccfu_flags_t;

  // True when a 32-bit value does not fit the signed 16-bit range.
  function automatic logic outside_s16(input logic [DataW-1:0] val);
    outside_s16 = (val[31:16] != {16{val[15]}});
  endfunction

endpackage

>>> rtl/core/ccfu_in_if.sv
// ----------------------------------------------------------------------------
// ccfu_in_if: input channel of the condition code flag unit
// Valid/ready channel carrying one flag update request per transaction.
// ----------------------------------------------------------------------------
interface ccfu_in_if;
  import ccfu_pkg::*;

  logic                valid;
  logic                ready;
  logic [DataW-1:0]    result_value;
  logic [DataW-1:0]    source_value;
  logic [DataW-1:0]    dest_value;
  logic [SizeW-1:0]    size_code;
  logic [CRuleW-1:0]   carry_rule;
  logic [VRuleW-1:0]   overflow_rule;
  logic                update_negative;
  logic                update_zero;

  modport source (
    output valid, result_value, source_value, dest_value, size_code,
           carry_rule, overflow_rule, update_negative, update_zero,
    input  ready
  );

  modport sink (
    input  valid, result_value, source_value, dest_value, size_code,
           carry_rule, overflow_rule, update_negative, update_zero,
    output ready
  );
endinterface

>>> rtl/core/ccfu_out_if.sv
// ----------------------------------------------------------------------------
// ccfu_out_if: result channel of the condition code flag unit
// Valid/ready channel carrying the four updated flags per transaction.
// ----------------------------------------------------------------------------
interface ccfu_out_if;
  logic valid;
  logic ready;
  logic flag_n;
  logic flag_z;
  logic flag_v;
  logic flag_c;

  modport source (
    output valid, flag_n, flag_z, flag_v, flag_c,
    input  ready
  );

  modport sink (
    input  valid, flag_n, flag_z, flag_v, flag_c,
    output ready
  );
endinterface

>>> rtl/core/ccfu_flag_logic.sv
// ----------------------------------------------------------------------------
// ccfu_flag_logic: next-flag computation
// Derives the new NZVC flags from one registered item and the current flags.
// ----------------------------------------------------------------------------
module ccfu_flag_logic (
  input  ccfu_pkg::ccfu_item_t  item,
  input  ccfu_pkg::ccfu_flags_t flags_cur,
  output ccfu_pkg::ccfu_flags_t flags_new
);
  import ccfu_pkg::*;

  logic [DataW-1:0] r, s, d;
  logic [5:0]       bits_w;
  logic [4:0]       msb;
  logic [DataW-1:0] low_mask;
  logic             rb, sb, db, s_neg, s_zero;

  // Arithmetic shift helpers
  logic             ash_left_over;
  logic [5:0]       ash_left_diff;
  logic [DataW-1:0] s_inv;
  logic [4:0]       ash_right_pos;
  logic             ash_c;
  logic             ash_big;
  logic [DataW-1:0] ash_ones;
  logic [4:0]       ash_shamt;
  logic [DataW-1:0] ash_mask;
  logic [DataW-1:0] ash_val;
  logic             ash_v;

  logic             c_new, n_new, v_new, z_new;

  assign r = item.result_value;
  assign s = item.source_value;
  assign d = item.dest_value;

  always_comb begin
    case (size_code_t'(item.size_code))
      SIZE_BYTE: begin
        bits_w   = 6'd8;
        msb      = 5'd7;
        low_mask = 32'h0000_00FF;
      end
      SIZE_WORD: begin
        bits_w   = 6'd16;
        msb      = 5'd15;
        low_mask = 32'h0000_FFFF;
      end
      default: begin
        bits_w   = 6'd32;
        msb      = 5'd31;
        low_mask = 32'hFFFF_FFFF;
      end
    endcase
  end

  assign rb     = r[msb];
  assign sb     = s[msb];
  assign db     = d[msb];
  assign s_neg  = s[DataW-1];
  assign s_zero = (s == '0);

  // Left count: C is bit (bits - count) of dest, zero beyond the width
  assign ash_left_over = (s > {26'd0, bits_w});
  assign ash_left_diff = bits_w - s[5:0];
  // Right count: position count-1 equals ~s, saturated at bit 31
  assign s_inv         = ~s;
  assign ash_right_pos = (s_inv > 32'd31) ? 5'd31 : s_inv[4:0];
  assign ash_c = s_neg ? d[ash_right_pos]
                       : (ash_left_over ? 1'b0 : d[ash_left_diff[4:0]]);

  // Overflow mask covers bits msb-count .. msb-1 of the magnitude
  assign ash_big   = (s >= {26'd0, bits_w});
  assign ash_ones  = (32'd1 << s[4:0]) - 32'd1;
  assign ash_shamt = msb - s[4:0];
  assign ash_mask  = (s_neg || s_zero) ? '0
                   : (ash_big ? '1 : (ash_ones << ash_shamt));
  assign ash_val   = db ? ~d : d;
  assign ash_v     = ((ash_val & ash_mask) != '0);

  always_comb begin
    case (carry_rule_t'(item.carry_rule))
      C_CLEAR: c_new = 1'b0;
      C_SET:   c_new = 1'b1;
      C_ADD:   c_new = (sb & db) | (~rb & db) | (sb & ~rb);
      C_SUB:   c_new = (sb & ~db) | (rb & ~db) | (sb & rb);
      C_LEFT:  c_new = sb;
      C_RIGHT: c_new = s[0];
      C_ASH:   c_new = s_zero ? flags_cur.c : ash_c;
      C_MUL:   c_new = outside_s16(r);
      C_DIV:   c_new = s_zero;
      default: c_new = flags_cur.c;
    endcase
  end

  assign n_new = item.update_negative ? rb : flags_cur.n;

  always_comb begin
    case (overflow_rule_t'(item.overflow_rule))
      V_CLEAR: v_new = 1'b0;
      V_ADD:   v_new = (sb & db & ~rb) | (~sb & ~db & rb);
      V_SUB:   v_new = (~sb & db & ~rb) | (sb & ~db & rb);
      V_SHIFT: v_new = n_new ^ c_new;
      V_ASH:   v_new = ash_v;
      V_DIV:   v_new = s_zero | outside_s16(r);
      default: v_new = flags_cur.v;
    endcase
  end

  assign z_new = item.update_zero ? ((r & low_mask) == '0) : flags_cur.z;

  assign flags_new = '{n: n_new, z: z_new, v: v_new, c: c_new};

endmodule

>>> rtl/core/condition_code_flag_unit.sv
// ----------------------------------------------------------------------------
// condition_code_flag_unit: NZVC condition code register with update rules
// Keeps the four status flags and applies one rule set per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : valid/ready channel; each transaction brings the result, source
//            and destination operands, the operand size, a carry rule, an
//            overflow rule and the N/Z update enables.
//   out_if : valid/ready channel; each transaction returns the four flags
//            as they stand after that update, one result per input.
//   Path: the input register captures at the accepting edge, then the flag
//            register that drives the outputs takes the result once the
//            output slot is free or draining, and output valid rises.
//   Throughput: one transaction per cycle while out_if.ready is high; the
//            flag logic is a single combinational pass from the input
//            register to the flag register, also serving as result register.
//   Reset (rst_n low, synchronous): flags clear to zero, both stages empty.
//   Stall: when out_if.ready is low the result holds; the input register
//            still takes one more transaction, then in_if.ready drops.
// ----------------------------------------------------------------------------
module condition_code_flag_unit (
  input  logic           clk,
  input  logic           rst_n,
  ccfu_in_if.sink        in_if,
  ccfu_out_if.source     out_if
);
  import ccfu_pkg::*;

  logic        in_vld_r;
  ccfu_item_t  in_item_r;
  logic        out_vld_r;
  ccfu_flags_t flags_r;
  ccfu_flags_t flags_nxt;
  logic        advance;
  logic        in_take;

  // Advance the registered item into the flag register when the result slot
  // is free or being drained this cycle.
  assign advance = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  // Payload register: capture only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= '{result_value:    in_if.result_value,
                     source_value:    in_if.source_value,
                     dest_value:      in_if.dest_value,
                     size_code:       in_if.size_code,
                     carry_rule:      in_if.carry_rule,
                     overflow_rule:   in_if.overflow_rule,
                     update_negative: in_if.update_negative,
                     update_zero:     in_if.update_zero};
    end
  end

  ccfu_flag_logic u_flag_logic (
    .item      (in_item_r),
    .flags_cur (flags_r),
    .flags_new (flags_nxt)
  );

  // The flag state doubles as the result payload: it only changes when a
  // new result enters the output slot, so a held result never moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        flags_r <= flags_nxt;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_if.valid  = out_vld_r;
  assign out_if.flag_n = flags_r.n;
  assign out_if.flag_z = flags_r.z;
  assign out_if.flag_v = flags_r.v;
  assign out_if.flag_c = flags_r.c;

endmodule
